// ===== hw/rtl/dq_pkg.sv =====
// Shared types and constants for the double-ended queue core.
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int WORD_W = 32;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } dq_mode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } dq_status_t;

  typedef struct packed {
    dq_mode_t                  mode;
    logic signed [WORD_W-1:0]  value;
  } dq_cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  back_value;
    logic [COUNT_OUT_W-1:0]    count;
    dq_status_t                status;
  } dq_res_t;

endpackage

// ===== hw/rtl/double_ended_queue_core.sv =====
// A command beat's memory read and pending result are registered when the beat is taken,
// and the result register loads from them while busy; no beat is taken while busy,
// nor while res_stall holds a waiting result.
// Reset clears the head pointer, the count and the handshake state; the word memory
// is not cleared, as only words written by a push are ever read.
// Both ends are read from one memory with two read ports and one write port.
module double_ended_queue_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  dq_pkg::dq_cmd_t  cmd,
  output logic             res_valid,
  input  logic             res_stall,
  output dq_pkg::dq_res_t  res
);
  import dq_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  held_next;
  logic              busy;
  logic              cmd_accept;

  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [PTR_W-1:0]  front_addr;
  logic [PTR_W-1:0]  back_addr;
  dq_status_t        status_next;

  logic signed [WORD_W-1:0] rd_front;
  logic signed [WORD_W-1:0] rd_back;
  logic signed [WORD_W-1:0] fwd_word;
  logic                     fwd_front;
  logic                     fwd_back;
  logic                     pend_empty;
  logic [CNT_W-1:0]         pend_count;
  dq_status_t               pend_status;

  function automatic logic [PTR_W-1:0] wrap_sum(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    begin
      r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
      wrap_sum = r[PTR_W-1:0];
    end
  endfunction

  assign cmd_accept = cmd_valid && !cmd_stall;
  // No beat enters while busy, and the result register must be free, or emptying this cycle, before a new beat enters.
  assign cmd_stall  = busy || (res_valid && res_stall);

  always_comb begin
    head_next   = head;
    held_next   = held;
    wr_en       = 1'b0;
    wr_addr     = head;
    status_next = STAT_DONE;
    case (cmd.mode)
      MODE_PUSH_FRONT: begin
        if (held == CNT_W'(DEPTH)) begin
          status_next = STAT_FULL;
        end else begin
          head_next = (head == '0) ? PTR_W'(DEPTH - 1) : head - PTR_W'(1);
          held_next = held + CNT_W'(1);
          wr_en     = 1'b1;
          wr_addr   = head_next;
        end
      end
      MODE_PUSH_BACK: begin
        if (held == CNT_W'(DEPTH)) begin
          status_next = STAT_FULL;
        end else begin
          held_next = held + CNT_W'(1);
          wr_en     = 1'b1;
          wr_addr   = wrap_sum(SUM_W'(head) + SUM_W'(held));
        end
      end
      MODE_POP_FRONT: begin
        if (held == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          head_next = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
          held_next = held - CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (held == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          held_next = held - CNT_W'(1);
        end
      end
      default: begin
        status_next = STAT_DONE;
      end
    endcase
  end

  always_comb begin
    front_addr = head_next;
    if (held_next == '0) begin
      back_addr = head_next;
    end else begin
      back_addr = wrap_sum(SUM_W'(head_next) + SUM_W'(held_next) - SUM_W'(1));
    end
  end

  // The memory reads old contents when an entry is written in the same cycle,
  // so the pushed word is carried alongside and chosen in the next cycle.
  always_ff @(posedge clk) begin
    if (cmd_accept && wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (cmd_accept) begin
      rd_front <= mem[front_addr];
      rd_back  <= mem[back_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      fwd_word    <= cmd.value;
      fwd_front   <= wr_en && (wr_addr == front_addr);
      fwd_back    <= wr_en && (wr_addr == back_addr);
      pend_empty  <= (held_next == '0);
      pend_count  <= held_next;
      pend_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      held <= '0;
      busy <= 1'b0;
    end else begin
      if (cmd_accept) begin
        head <= head_next;
        held <= held_next;
      end
      busy <= cmd_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (busy) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      res.front_value <= pend_empty ? '0 : (fwd_front ? fwd_word : rd_front);
      res.back_value  <= pend_empty ? '0 : (fwd_back ? fwd_word : rd_back);
      res.count       <= COUNT_OUT_W'(pend_count);
      res.status      <= pend_status;
    end
  end

endmodule
